FILE: design/resp_stream_parser_top_macros.svh
// ----------------------------------------------------------------------------
// resp_stream_parser_top_macros.svh
// Assertion helper macros for the RESP stream parser.
// ----------------------------------------------------------------------------
`ifndef RESP_STREAM_PARSER_TOP_MACROS_SVH
`define RESP_STREAM_PARSER_TOP_MACROS_SVH

// Same-cycle implication, clocked on clk, disabled in reset.
`define RSP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, disabled in reset.
`define RSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/rsp_pkg.sv
// ----------------------------------------------------------------------------
// rsp_pkg
// Shared types and constants for the RESP stream parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rsp_pkg;

    localparam int DEP_W    = 5;
    localparam int NUM_W    = 64;
    localparam int TDATA_W  = 88;

    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOLL  = 8'h24;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_VT    = 8'd11;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [NUM_W-1:0] MAG_LIM = {1'b1, {(NUM_W-1){1'b0}}};
    localparam logic [NUM_W-1:0] POS_MAX = {1'b0, {(NUM_W-1){1'b1}}};

    typedef enum logic [3:0] {
        TK_SIMPLE   = 4'd0,
        TK_ERRBYTE  = 4'd1,
        TK_BULKBYTE = 4'd2,
        TK_INTEGER  = 4'd3,
        TK_BULKHDR  = 4'd4,
        TK_ARRHDR   = 4'd5,
        TK_NULLBULK = 4'd6,
        TK_NULLARR  = 4'd7,
        TK_STREND   = 4'd8,
        TK_ERROR    = 4'd9
    } token_kind_t;

    typedef enum logic [2:0] {
        ERR_NONE    = 3'd0,
        ERR_SHORT   = 3'd1,
        ERR_TYPE    = 3'd2,
        ERR_STRAY   = 3'd3,
        ERR_DEEP    = 3'd4,
        ERR_LEN     = 3'd5
    } err_code_t;

    typedef enum logic [2:0] {
        LT_SIMPLE  = 3'd0,
        LT_ERROR   = 3'd1,
        LT_INTEGER = 3'd2,
        LT_BULK    = 3'd3,
        LT_ARRAY   = 3'd4
    } line_type_t;

    typedef enum logic [2:0] {
        PH_TYPE = 3'd0,
        PH_BODY = 3'd1,
        PH_BULK = 3'd2,
        PH_TR1  = 3'd3,
        PH_TR2  = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        NS_SKIP = 2'd0,
        NS_SIGN = 2'd1,
        NS_DIG  = 2'd2,
        NS_STOP = 2'd3
    } num_stage_t;

    typedef enum logic [1:0] {
        CT_IDLE  = 2'd0,
        CT_CHECK = 2'd1
    } ctl_state_t;

    // Control from the sequencer to the number reader
    typedef struct packed {
        logic       clear;
        logic       feed;
        logic [7:0] ch;
    } num_ctl_t;

endpackage

`default_nettype wire

FILE: design/resp_stream_parser_top.sv
// ----------------------------------------------------------------------------
// resp_stream_parser_top
// Byte-serial RESP2 parser emitting one token item per significant byte.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries the raw protocol stream, one byte per item in tdata[7:0].
//   m_axis carries token items: tuser is the token kind, tlast flags a
//   completed top-level value, tdata holds the remaining token fields.
//   A byte that yields a token with no nesting walk puts the token in the
//   output register the cycle after the byte is accepted.
//   A byte that completes a value inside open arrays walks the element-count
//   stack held in a one-port-read RAM, one RAM read per level, with
//   registered read data, before its token is emitted.
//   Bytes are taken one at a time: a new byte is accepted only when the
//   sequencer is idle and the output register is empty or being drained.
//   When the receiver stalls, the token holds in the output register and
//   the input side stalls with it.
//   Reset clears the parse phase, number reader, bulk counter and stack
//   depth; stack RAM contents are not cleared, entries are only read below
//   the current depth, and all were written when pushed.
//   Any protocol error emits an error token and returns to the reset state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "resp_stream_parser_top_macros.svh"

module resp_stream_parser_top
    import rsp_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int COUNT_BITS = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [7:0]         s_axis_tdata,   // [7:0] in_byte
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [TDATA_W-1:0]      m_axis_tdata,   // [7:0] data_byte, [71:8] number,
                                                    // [76:72] depth, [77] value_end,
                                                    // [80:78] error_code, [87:81] zero
    output logic [3:0]              m_axis_tuser,   // [3:0] token_kind
    output logic                    m_axis_tlast    // message_done
);

    localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LCW = $clog2(DEPTH + 1);
    localparam logic [NUM_W-1:0] CNT_MAX = NUM_W'((65'd1 << COUNT_BITS) - 65'd1);

    // parse state
    phase_t                 phase_reg, phase_next;
    line_type_t             lt_reg, lt_next;
    logic                   pcr_reg, pcr_next;
    logic                   seen_reg, seen_next;
    logic [COUNT_BITS-1:0]  bl_reg, bl_next;
    logic [LCW-1:0]         lc_reg, lc_next;
    ctl_state_t             ct_reg, ct_next;

    // token waiting on the stack walk
    token_kind_t            tk_reg, tk_next;
    logic [NUM_W-1:0]       tnum_reg, tnum_next;
    logic [DEP_W-1:0]       tdep_reg, tdep_next;

    // output register
    logic                   ov_reg, ov_next;
    logic [3:0]             ou_reg, ou_next;
    logic [TDATA_W-1:0]     od_reg, od_next;
    logic                   ol_reg, ol_next;

    // emit request
    logic                   em;
    token_kind_t            em_kind;
    logic [7:0]             em_byte;
    logic [NUM_W-1:0]       em_num;
    logic [DEP_W-1:0]       em_dep;
    logic                   em_vend, em_done;
    err_code_t              em_err;

    // value completion request
    logic                   cpl;
    token_kind_t            cpl_kind;
    logic [NUM_W-1:0]       cpl_num;

    logic                   in_fire, fail;
    err_code_t              fail_code;
    logic [7:0]             b;
    num_ctl_t               nctl;
    logic [NUM_W-1:0]       nacc, val;
    logic                   nneg, negative, too_big;
    logic                   ram_we, ram_re;
    logic [AW-1:0]          ram_waddr, ram_raddr;
    logic [COUNT_BITS-1:0]  ram_wdata, ram_rdata, dec;

    rsp_num u_num (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (nctl),
        .acc   (nacc),
        .neg   (nneg)
    );

    rsp_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_axis_tready = (ct_reg == CT_IDLE) && (!ov_reg || m_axis_tready);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign b             = s_axis_tdata;

    always_comb
    begin
        negative = nneg && (nacc != '0);
        val      = nneg ? (NUM_W'(0) - nacc) : (nacc[NUM_W-1] ? POS_MAX : nacc);
        too_big  = nacc > CNT_MAX;
        dec      = (ram_rdata != '0) ? (ram_rdata - 1'b1) : '0;
    end

    always_comb
    begin
        phase_next = phase_reg;
        lt_next    = lt_reg;
        pcr_next   = pcr_reg;
        seen_next  = seen_reg;
        bl_next    = bl_reg;
        lc_next    = lc_reg;
        ct_next    = ct_reg;
        tk_next    = tk_reg;
        tnum_next  = tnum_reg;
        tdep_next  = tdep_reg;
        em         = 1'b0;
        em_kind    = TK_SIMPLE;
        em_byte    = '0;
        em_num     = '0;
        em_dep     = DEP_W'(lc_reg);
        em_vend    = 1'b0;
        em_done    = 1'b0;
        em_err     = ERR_NONE;
        cpl        = 1'b0;
        cpl_kind   = TK_STREND;
        cpl_num    = '0;
        fail       = 1'b0;
        fail_code  = ERR_NONE;
        nctl.clear = 1'b0;
        nctl.feed  = 1'b0;
        nctl.ch    = b;
        ram_we     = 1'b0;
        ram_waddr  = AW'(lc_reg);
        ram_wdata  = nacc[COUNT_BITS-1:0];
        ram_re     = 1'b0;
        ram_raddr  = AW'(lc_reg - 1'b1);

        unique case (ct_reg)
            CT_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (phase_reg)
                        PH_TYPE:
                        begin
                            phase_next = PH_BODY;
                            pcr_next   = 1'b0;
                            seen_next  = 1'b0;
                            nctl.clear = 1'b1;
                            priority if (b == CH_PLUS)  lt_next = LT_SIMPLE;
                            else if (b == CH_MINUS)     lt_next = LT_ERROR;
                            else if (b == CH_COLON)     lt_next = LT_INTEGER;
                            else if (b == CH_DOLL)      lt_next = LT_BULK;
                            else if (b == CH_STAR)      lt_next = LT_ARRAY;
                            else if (b == CH_CR || b == CH_LF)
                            begin
                                fail = 1'b1; fail_code = ERR_SHORT;
                            end
                            else
                            begin
                                fail = 1'b1; fail_code = ERR_TYPE;
                            end
                        end
                        PH_BODY:
                        begin
                            if (pcr_reg)
                            begin
                                pcr_next = 1'b0;
                                if (b != CH_LF)
                                begin
                                    fail = 1'b1; fail_code = ERR_STRAY;
                                end
                                else if (!seen_reg)
                                begin
                                    fail = 1'b1; fail_code = ERR_SHORT;
                                end
                                else
                                begin
                                    // end of line
                                    phase_next = PH_TYPE;
                                    unique case (lt_reg)
                                        LT_SIMPLE, LT_ERROR:
                                        begin
                                            cpl = 1'b1; cpl_kind = TK_STREND;
                                        end
                                        LT_INTEGER:
                                        begin
                                            cpl = 1'b1; cpl_kind = TK_INTEGER;
                                            cpl_num = val;
                                        end
                                        LT_BULK:
                                        begin
                                            if (negative)
                                            begin
                                                cpl = 1'b1; cpl_kind = TK_NULLBULK;
                                                cpl_num = val;
                                            end
                                            else if (too_big)
                                            begin
                                                fail = 1'b1; fail_code = ERR_LEN;
                                            end
                                            else
                                            begin
                                                bl_next    = nacc[COUNT_BITS-1:0];
                                                phase_next = (nacc != '0) ? PH_BULK : PH_TR1;
                                                em = 1'b1; em_kind = TK_BULKHDR;
                                                em_num = val;
                                            end
                                        end
                                        default:
                                        begin
                                            if (negative)
                                            begin
                                                cpl = 1'b1; cpl_kind = TK_NULLARR;
                                                cpl_num = val;
                                            end
                                            else if (too_big)
                                            begin
                                                fail = 1'b1; fail_code = ERR_LEN;
                                            end
                                            else if (nacc == '0)
                                            begin
                                                cpl = 1'b1; cpl_kind = TK_ARRHDR;
                                            end
                                            else if (lc_reg >= LCW'(DEPTH))
                                            begin
                                                fail = 1'b1; fail_code = ERR_DEEP;
                                            end
                                            else
                                            begin
                                                ram_we  = 1'b1;
                                                lc_next = lc_reg + 1'b1;
                                                em = 1'b1; em_kind = TK_ARRHDR;
                                                em_num = val;
                                            end
                                        end
                                    endcase
                                end
                            end
                            else if (b == CH_CR)
                            begin
                                pcr_next = 1'b1;
                            end
                            else if (b == CH_LF)
                            begin
                                fail = 1'b1; fail_code = ERR_STRAY;
                            end
                            else
                            begin
                                seen_next = 1'b1;
                                if (lt_reg == LT_SIMPLE || lt_reg == LT_ERROR)
                                begin
                                    em      = 1'b1;
                                    em_kind = (lt_reg == LT_SIMPLE) ? TK_SIMPLE : TK_ERRBYTE;
                                    em_byte = b;
                                end
                                else
                                begin
                                    nctl.feed = 1'b1;
                                end
                            end
                        end
                        PH_BULK:
                        begin
                            bl_next = (bl_reg != '0) ? (bl_reg - 1'b1) : '0;
                            if (bl_next == '0)
                                phase_next = PH_TR1;
                            em = 1'b1; em_kind = TK_BULKBYTE; em_byte = b;
                        end
                        PH_TR1:
                        begin
                            phase_next = PH_TR2;
                        end
                        default:
                        begin
                            phase_next = PH_TYPE;
                            cpl = 1'b1; cpl_kind = TK_STREND;
                        end
                    endcase
                end

                if (cpl && !fail)
                begin
                    if (lc_reg == '0)
                    begin
                        em = 1'b1; em_kind = cpl_kind; em_num = cpl_num;
                        em_vend = 1'b1; em_done = 1'b1;
                    end
                    else
                    begin
                        // walk the count stack, starting at the top level
                        tk_next   = cpl_kind;
                        tnum_next = cpl_num;
                        tdep_next = DEP_W'(lc_reg);
                        ram_re    = 1'b1;
                        ct_next   = CT_CHECK;
                    end
                end
            end
            default:
            begin
                em_kind = tk_reg;
                em_num  = tnum_reg;
                em_dep  = tdep_reg;
                em_vend = 1'b1;
                if (dec != '0)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(lc_reg - 1'b1);
                    ram_wdata = dec;
                    em        = 1'b1;
                    ct_next   = CT_IDLE;
                end
                else
                begin
                    lc_next = lc_reg - 1'b1;
                    if (lc_next == '0)
                    begin
                        em      = 1'b1;
                        em_done = 1'b1;
                        ct_next = CT_IDLE;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = AW'(lc_next - 1'b1);
                    end
                end
            end
        endcase

        if (fail)
        begin
            phase_next = PH_TYPE;
            lt_next    = LT_SIMPLE;
            pcr_next   = 1'b0;
            seen_next  = 1'b0;
            bl_next    = '0;
            lc_next    = '0;
            ram_we     = 1'b0;
            nctl.clear = 1'b1;
            em = 1'b1; em_kind = TK_ERROR; em_byte = '0; em_num = '0;
            em_dep = '0; em_vend = 1'b0; em_done = 1'b0; em_err = fail_code;
        end

        ov_next = ov_reg;
        ou_next = ou_reg;
        od_next = od_reg;
        ol_next = ol_reg;
        if (m_axis_tready)
            ov_next = 1'b0;
        if (em)
        begin
            ov_next = 1'b1;
            ou_next = em_kind;
            ol_next = em_done;
            od_next = {7'd0, em_err, em_vend, em_dep, em_num, em_byte};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TYPE;
            lt_reg    <= LT_SIMPLE;
            pcr_reg   <= 1'b0;
            seen_reg  <= 1'b0;
            bl_reg    <= '0;
            lc_reg    <= '0;
            ct_reg    <= CT_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            lt_reg    <= lt_next;
            pcr_reg   <= pcr_next;
            seen_reg  <= seen_next;
            bl_reg    <= bl_next;
            lc_reg    <= lc_next;
            ct_reg    <= ct_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tk_reg   <= tk_next;
        tnum_reg <= tnum_next;
        tdep_reg <= tdep_next;
        ou_reg   <= ou_next;
        od_reg   <= od_next;
        ol_reg   <= ol_next;
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tuser  = ou_reg;
    assign m_axis_tdata  = od_reg;
    assign m_axis_tlast  = ol_reg;

    `RSP_ASSERT_NOW(a_depth_bound, 1'b1, lc_reg <= LCW'(DEPTH), "stack depth past limit")
    `RSP_ASSERT_NOW(a_walk_nonempty, ct_reg == CT_CHECK, lc_reg != '0, "walk on empty stack")
    `RSP_ASSERT_NOW(a_err_code, m_axis_tvalid && m_axis_tuser == TK_ERROR,
        m_axis_tdata[80:78] != ERR_NONE && !m_axis_tlast, "error token without code")
    `RSP_ASSERT_NEXT(a_walk_out_free, ct_reg == CT_IDLE && ct_next == CT_CHECK,
        !m_axis_tvalid, "walk started with output busy")

endmodule

`default_nettype wire

FILE: design/rsp_ram.sv
// ----------------------------------------------------------------------------
// rsp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: design/rsp_num.sv
// ----------------------------------------------------------------------------
// rsp_num
// Decimal reader: optional blanks, one sign, digits; saturating magnitude.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsp_num
    import rsp_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire num_ctl_t         ctl,
    output logic      [NUM_W-1:0] acc,
    output logic                  neg
);

    logic [NUM_W-1:0] acc_reg, acc_next;
    logic             neg_reg, neg_next;
    num_stage_t       stage_reg, stage_next;
    logic             is_digit, is_blank, is_sign;
    logic [NUM_W+3:0] prod;

    always_comb
    begin
        is_digit   = (ctl.ch >= CH_ZERO) && (ctl.ch <= CH_NINE);
        is_blank   = (ctl.ch == CH_SPACE) || (ctl.ch == CH_TAB) ||
                     (ctl.ch == CH_VT) || (ctl.ch == CH_FF);
        is_sign    = (ctl.ch == CH_PLUS) || (ctl.ch == CH_MINUS);
        prod       = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1)
                     + (NUM_W+4)'(ctl.ch - CH_ZERO);
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        stage_next = stage_reg;
        if (ctl.clear)
        begin
            acc_next   = '0;
            neg_next   = 1'b0;
            stage_next = NS_SKIP;
        end
        else if (ctl.feed)
        begin
            unique case (stage_reg)
                NS_SKIP:
                begin
                    if (is_sign)
                    begin
                        neg_next   = (ctl.ch == CH_MINUS);
                        stage_next = NS_SIGN;
                    end
                    else if (!is_blank)
                    begin
                        stage_next = is_digit ? NS_DIG : NS_STOP;
                    end
                end
                NS_SIGN: stage_next = is_digit ? NS_DIG : NS_STOP;
                NS_DIG:  stage_next = is_digit ? NS_DIG : NS_STOP;
                NS_STOP: stage_next = NS_STOP;
                default: stage_next = NS_STOP;
            endcase
            if (stage_next == NS_DIG && is_digit)
            begin
                // saturate once the magnitude passes 2^63
                if (prod > {4'd0, MAG_LIM})
                    acc_next = MAG_LIM;
                else
                    acc_next = prod[NUM_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            stage_reg <= NS_SKIP;
        end
        else
        begin
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
            stage_reg <= stage_next;
        end
    end

    assign acc = acc_reg;
    assign neg = neg_reg;

endmodule

`default_nettype wire

FILE: verif/tb_resp_stream_parser_top.sv
// ----------------------------------------------------------------------------
// tb_resp_stream_parser_top
// Self-checking bench for the RESP stream parser: directed table, then
// random well-formed messages mixed with noise, checked by a token predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_resp_stream_parser_top
    import rsp_pkg::*;
();

    localparam int DEPTH      = 16;
    localparam int COUNT_BITS = 32;

    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  data;
        logic [63:0] num;
        logic [4:0]  dep;
        logic        vend;
        logic        done;
        logic [2:0]  code;
    } token_t;

    // directed row: byte, and optionally a typed-in expected token
    typedef struct {
        logic [7:0] b;
        bit         fixed;
        token_t     tok;
    } row_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [TDATA_W-1:0] m_axis_tdata;
    logic [3:0] m_axis_tuser;
    logic m_axis_tlast;

    resp_stream_parser_top #(.DEPTH(DEPTH), .COUNT_BITS(COUNT_BITS)) dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    // ------------------------------------------------------------------
    // Predictor state (mirrors the parser's architectural state)
    // ------------------------------------------------------------------
    phase_t      p_phase;
    line_type_t  p_ltype;
    bit          p_cr;
    bit          p_body;
    logic [63:0] p_acc;
    bit          p_neg;
    num_stage_t  p_stage;
    logic [63:0] p_bulk;
    logic [63:0] p_lvl [DEPTH];
    int          p_lcount;

    token_t      tokens_due[$];
    int          errors;
    int          n_sent;
    int          n_tokens;
    int          n_done;
    int          n_err_tok;
    bit          hold_rx;
    bit          stim_done;

    function automatic void clear_pred();
        p_phase = PH_TYPE; p_ltype = LT_SIMPLE; p_cr = 0; p_body = 0;
        p_acc = '0; p_neg = 0; p_stage = NS_SKIP; p_bulk = '0; p_lcount = 0;
        for (int i = 0; i < DEPTH; i++) p_lvl[i] = '0;
    endfunction

    function automatic token_t mk(logic [3:0] k, logic [7:0] d, logic [63:0] n,
                                  int dp, bit ve, bit dn, logic [2:0] c);
        token_t t;
        t.kind = k; t.data = d; t.num = n; t.dep = dp[4:0];
        t.vend = ve; t.done = dn; t.code = c;
        return t;
    endfunction

    // count down the enclosing levels; 1 when top-level value finished
    function automatic bit pop_levels();
        while (p_lcount > 0)
        begin
            if (p_lvl[p_lcount-1] > 0) p_lvl[p_lcount-1]--;
            if (p_lvl[p_lcount-1] != 0) return 0;
            p_lcount--;
        end
        return 1;
    endfunction

    function automatic token_t err_tok(err_code_t c);
        clear_pred();
        return mk(TK_ERROR, 8'd0, 64'd0, 0, 0, 0, c);
    endfunction

    function automatic void feed_digit(logic [7:0] b);
        bit dig;
        logic [63:0] d;
        dig = (b >= CH_ZERO && b <= CH_NINE);
        if (p_stage == NS_SKIP)
        begin
            if (b == CH_SPACE || b == CH_TAB || b == CH_VT || b == CH_FF) return;
            if (b == CH_PLUS || b == CH_MINUS)
            begin
                p_neg = (b == CH_MINUS); p_stage = NS_SIGN; return;
            end
            p_stage = dig ? NS_DIG : NS_STOP;
        end
        else if (p_stage == NS_SIGN) p_stage = dig ? NS_DIG : NS_STOP;
        else if (p_stage == NS_DIG && !dig) p_stage = NS_STOP;
        if (p_stage == NS_DIG)
        begin
            d = 64'(b - CH_ZERO);
            if (p_acc > MAG_LIM / 10 || p_acc * 10 > MAG_LIM - d) p_acc = MAG_LIM;
            else p_acc = p_acc * 10 + d;
        end
    endfunction

    function automatic bit close_line(output token_t t);
        int dp;
        bit neg, dn;
        logic [63:0] v, maxc;
        dp = p_lcount;
        maxc = (64'd1 << COUNT_BITS) - 1;
        neg = p_neg && p_acc != 0;
        v = p_neg ? -p_acc : (p_acc > POS_MAX ? POS_MAX : p_acc);
        p_cr = 0;
        if (!p_body)
        begin
            t = err_tok(ERR_SHORT); return 1;
        end
        p_phase = PH_TYPE;
        case (p_ltype)
            LT_SIMPLE, LT_ERROR:
            begin
                dn = pop_levels(); t = mk(TK_STREND, 0, 0, dp, 1, dn, ERR_NONE);
            end
            LT_INTEGER:
            begin
                dn = pop_levels(); t = mk(TK_INTEGER, 0, v, dp, 1, dn, ERR_NONE);
            end
            LT_BULK:
            begin
                if (neg)
                begin
                    dn = pop_levels(); t = mk(TK_NULLBULK, 0, v, dp, 1, dn, ERR_NONE);
                end
                else if (p_acc > maxc) t = err_tok(ERR_LEN);
                else
                begin
                    p_bulk = p_acc;
                    p_phase = (p_acc != 0) ? PH_BULK : PH_TR1;
                    t = mk(TK_BULKHDR, 0, v, dp, 0, 0, ERR_NONE);
                end
            end
            default:
            begin
                if (neg)
                begin
                    dn = pop_levels(); t = mk(TK_NULLARR, 0, v, dp, 1, dn, ERR_NONE);
                end
                else if (p_acc > maxc) t = err_tok(ERR_LEN);
                else if (p_acc == 0)
                begin
                    dn = pop_levels(); t = mk(TK_ARRHDR, 0, 0, dp, 1, dn, ERR_NONE);
                end
                else if (p_lcount >= DEPTH) t = err_tok(ERR_DEEP);
                else
                begin
                    p_lvl[p_lcount] = p_acc; p_lcount++;
                    t = mk(TK_ARRHDR, 0, v, dp, 0, 0, ERR_NONE);
                end
            end
        endcase
        return 1;
    endfunction

    // one byte in, zero or one token out
    function automatic bit predict_token(logic [7:0] b, output token_t t);
        int dp;
        bit dn;
        t = '0;
        case (p_phase)
            PH_TYPE:
            begin
                case (b)
                    CH_PLUS:  p_ltype = LT_SIMPLE;
                    CH_MINUS: p_ltype = LT_ERROR;
                    CH_COLON: p_ltype = LT_INTEGER;
                    CH_DOLL:  p_ltype = LT_BULK;
                    CH_STAR:  p_ltype = LT_ARRAY;
                    CH_CR, CH_LF:
                    begin
                        t = err_tok(ERR_SHORT); return 1;
                    end
                    default:
                    begin
                        t = err_tok(ERR_TYPE); return 1;
                    end
                endcase
                p_phase = PH_BODY; p_cr = 0; p_body = 0;
                p_acc = '0; p_neg = 0; p_stage = NS_SKIP;
                return 0;
            end
            PH_BODY:
            begin
                if (p_cr)
                begin
                    if (b == CH_LF) return close_line(t);
                    t = err_tok(ERR_STRAY); return 1;
                end
                if (b == CH_CR)
                begin
                    p_cr = 1; return 0;
                end
                if (b == CH_LF)
                begin
                    t = err_tok(ERR_STRAY); return 1;
                end
                p_body = 1;
                if (p_ltype == LT_SIMPLE || p_ltype == LT_ERROR)
                begin
                    t = mk(p_ltype == LT_SIMPLE ? TK_SIMPLE : TK_ERRBYTE, b, 0,
                           p_lcount, 0, 0, ERR_NONE);
                    return 1;
                end
                feed_digit(b);
                return 0;
            end
            PH_BULK:
            begin
                if (p_bulk > 0) p_bulk--;
                if (p_bulk == 0) p_phase = PH_TR1;
                t = mk(TK_BULKBYTE, b, 0, p_lcount, 0, 0, ERR_NONE);
                return 1;
            end
            PH_TR1:
            begin
                p_phase = PH_TR2; return 0;
            end
            default:
            begin
                dp = p_lcount; p_phase = PH_TYPE;
                dn = pop_levels();
                t = mk(TK_STREND, 0, 0, dp, 1, dn, ERR_NONE);
                return 1;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset, timeout
    // ------------------------------------------------------------------
    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sender: drives one byte at the falling edge, predicts on acceptance
    // ------------------------------------------------------------------
    task automatic gap_cycles();
        int g;
        g = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) g = 0;
        repeat (g) @(negedge clk);
    endtask

    task automatic put_byte(logic [7:0] b, bit fixed, token_t ft, bit gaps);
        token_t t;
        bit has;
        if (gaps) gap_cycles();
        s_axis_tvalid = 1; s_axis_tdata = b;
        do @(posedge clk); while (!s_axis_tready);
        has = predict_token(b, t);
        if (has)
        begin
            if (fixed && t !== ft)
            begin
                $error("table row mismatch byte=%h exp=%h pred=%h", b, ft, t);
                errors++;
            end
            tokens_due.insert(tokens_due.size(), t);
        end
        n_sent++;
        @(negedge clk);
        s_axis_tvalid = 0;
    endtask

    task automatic put_str(string s, bit gaps);
        for (int i = 0; i < s.len(); i++) put_byte(s[i], 0, '0, gaps);
    endtask

    // random well-formed value, nested up to lim levels
    task automatic put_value(int lim);
        int sel, n;
        sel = $urandom_range(0, (lim > 0) ? 6 : 4);
        case (sel)
            0:
            begin
                put_str("+", 1);
                n = $urandom_range(1, 5);
                repeat (n) put_byte(8'($urandom_range(32, 126)), 0, '0, 1);
                put_str("\r\n", 1);
            end
            1:
            begin
                put_str("-ERR ", 1);
                put_byte(8'($urandom_range(0, 255)) & 8'hF7 | 8'h80, 0, '0, 1);
                put_str("\r\n", 1);
            end
            2:
            begin
                if ($urandom_range(0, 4) == 0) put_str(":-9223372036854775809\r\n", 1);
                else put_str($sformatf(":%s%0d\r\n", $urandom_range(0, 1) ? "-" : " ",
                                       $urandom()), 1);
            end
            3:
            begin
                n = $urandom_range(0, 6);
                put_str($sformatf("$%0d\r\n", n), 1);
                repeat (n) put_byte(8'($urandom()), 0, '0, 1);
                put_byte(8'($urandom()), 0, '0, 1);
                put_byte(8'($urandom()), 0, '0, 1);
            end
            4: put_str($urandom_range(0, 1) ? "$-1\r\n" : "*-1\r\n", 1);
            default:
            begin
                n = $urandom_range(0, 3);
                put_str($sformatf("*%0d\r\n", n), 1);
                repeat (n) put_value(lim - 1);
            end
        endcase
    endtask

    task automatic wait_empty();
        while (tokens_due.size() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    row_t dir_rows[$];

    task automatic add_row(logic [7:0] b);
        row_t r;
        r.b = b; r.fixed = 0; r.tok = '0;
        dir_rows.insert(dir_rows.size(), r);
    endtask

    task automatic add_fixed(logic [7:0] b, token_t t);
        row_t r;
        r.b = b; r.fixed = 1; r.tok = t;
        dir_rows.insert(dir_rows.size(), r);
    endtask

    initial
    begin
        int k;
        string big_len;
        errors = 0; n_sent = 0; n_tokens = 0; n_done = 0; n_err_tok = 0;
        hold_rx = 0; stim_done = 0;
        s_axis_tvalid = 0; s_axis_tdata = '0;
        rst_n = 0;
        clear_pred();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed table: error codes, empty body, extremes, empty array
        add_fixed(CH_LF, mk(TK_ERROR, 0, 0, 0, 0, 0, ERR_SHORT));
        add_fixed(8'hFF, mk(TK_ERROR, 0, 0, 0, 0, 0, ERR_TYPE));
        add_row(CH_PLUS);
        add_fixed(CH_CR, '0);
        add_fixed(CH_LF, mk(TK_ERROR, 0, 0, 0, 0, 0, ERR_SHORT));
        add_row(CH_COLON);
        add_fixed(CH_LF, mk(TK_ERROR, 0, 0, 0, 0, 0, ERR_STRAY));
        add_row(CH_STAR); add_row("0"); add_row(CH_CR);
        add_fixed(CH_LF, mk(TK_ARRHDR, 0, 0, 0, 1, 1, ERR_NONE));
        add_row(CH_MINUS);
        add_fixed(8'h00, mk(TK_ERRBYTE, 8'h00, 0, 0, 0, 0, ERR_NONE));
        add_row(CH_CR);
        add_fixed(8'h41, mk(TK_ERROR, 0, 0, 0, 0, 0, ERR_STRAY));
        add_row(CH_DOLL);
        big_len = "4294967296";
        for (int i = 0; i < big_len.len(); i++) add_row(big_len[i]);
        add_row(CH_CR);
        add_fixed(CH_LF, mk(TK_ERROR, 0, 0, 0, 0, 0, ERR_LEN));
        add_row(CH_DOLL); add_row("0"); add_row(CH_CR);
        add_fixed(CH_LF, mk(TK_BULKHDR, 0, 0, 0, 0, 0, ERR_NONE));
        add_row(8'hAA); add_row(8'h55);
        foreach (dir_rows[i]) put_byte(dir_rows[i].b, dir_rows[i].fixed, dir_rows[i].tok, 0);
        put_str(":99999999999999999999\r\n", 0);
        put_str(":\t+12x7\r\n", 0);
        put_str("*4294967295\r\n", 0);
        wait_empty();
        // too deep: 17 nested opens
        repeat (17) put_str("*1\r\n", 0);
        put_str("$-1\r\n", 0);

        // receiver holds off while the sender keeps offering
        hold_rx = 1;
        fork
            begin
                repeat (300) @(negedge clk);
                hold_rx = 0;
            end
            put_str("*3\r\n+hello\r\n$2\r\nab\r\n:-5\r\n", 0);
        join
        wait_empty();

        // random part: mostly well-formed messages, some noise
        while (n_sent < 1850)
        begin
            k = $urandom_range(0, 9);
            if (k == 0) put_byte(8'($urandom()), 0, '0, 1);
            else if (k == 1) put_str("*2\r\n+x\r", 1);
            else put_value(3);
            if ($urandom_range(0, 60) == 0) wait_empty();
        end
        put_str("+z\r\n", 1);
        stim_done = 1;
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, field-by-field compare at rising edge
    // ------------------------------------------------------------------
    initial
    begin
        int g;
        m_axis_tready = 0;
        forever
        begin
            @(negedge clk);
            if (hold_rx) m_axis_tready <= 0;
            else
            begin
                g = ($urandom_range(0, 24) == 0) ? $urandom_range(5, 30)
                                                 : ($urandom_range(0, 2) == 0);
                if ($urandom_range(0, 2) == 0) g = 0;
                if (g > 0)
                begin
                    m_axis_tready <= 0;
                    repeat (g) @(negedge clk);
                end
                m_axis_tready <= 1;
            end
        end
    end

    always @(posedge clk)
    begin
        token_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            n_tokens++;
            if (tokens_due.size() == 0)
            begin
                $error("token with nothing expected: tuser=%0d", m_axis_tuser);
                errors++;
            end
            else
            begin
                e = tokens_due.pop_front();
                if (e.done) n_done++;
                if (e.kind == TK_ERROR) n_err_tok++;
                if (m_axis_tuser !== e.kind)
                begin
                    $error("token_kind exp=%0d act=%0d", e.kind, m_axis_tuser); errors++;
                end
                if (m_axis_tdata[7:0] !== e.data)
                begin
                    $error("data_byte exp=%h act=%h", e.data, m_axis_tdata[7:0]); errors++;
                end
                if (m_axis_tdata[71:8] !== e.num)
                begin
                    $error("number exp=%0d act=%0d", $signed(e.num),
                           $signed(m_axis_tdata[71:8])); errors++;
                end
                if (m_axis_tdata[76:72] !== e.dep)
                begin
                    $error("depth exp=%0d act=%0d", e.dep, m_axis_tdata[76:72]); errors++;
                end
                if (m_axis_tdata[77] !== e.vend)
                begin
                    $error("value_end exp=%b act=%b", e.vend, m_axis_tdata[77]); errors++;
                end
                if (m_axis_tlast !== e.done)
                begin
                    $error("message_done exp=%b act=%b", e.done, m_axis_tlast); errors++;
                end
                if (m_axis_tdata[80:78] !== e.code)
                begin
                    $error("error_code exp=%0d act=%0d", e.code, m_axis_tdata[80:78]);
                    errors++;
                end
            end
        end
    end

    // end of run
    initial
    begin
        wait (stim_done);
        while (tokens_due.size() != 0) @(negedge clk);
        repeat (50) @(negedge clk);
        $display("Sent %0d bytes, checked %0d tokens (%0d messages done, %0d errors).",
                 n_sent, n_tokens, n_done, n_err_tok);
        if (errors == 0 && tokens_due.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: files.f
+incdir+design
design/rsp_pkg.sv
design/rsp_ram.sv
design/rsp_num.sv
design/resp_stream_parser_top.sv
verif/tb_resp_stream_parser_top.sv
